>>> rtl/core/led_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pkg
// Shared types and constants of the local extrema detector: field widths,
// register indexes and reset values, trend and compare codes.
// ----------------------------------------------------------------------------
package led_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 16;

    localparam int TOL_BITS        = 16;
    localparam int MODE_BITS       = 2;
    localparam int POS_BITS        = 16;
    localparam int PEAK_BITS       = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_TOL  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_MODE = 2'd1;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 16'd1;
    localparam logic [MODE_BITS-1:0] MODE_RESET = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_MAX_ONLY = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MIN_ONLY = 2'd1;

    typedef enum logic [1:0] {
        TREND_UNKNOWN = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2
    } t_trend;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_GT = 2'd1,
        CMP_LT = 2'd2
    } t_cmp;

endpackage

>>> rtl/core/led_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_if
// Handshake channels of the local extrema detector: sample input, extremum
// output and register write port.
// ----------------------------------------------------------------------------
interface led_in_if
    import led_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          record_end;

    modport source (output valid, output sample, output record_end, input ready);
    modport sink   (input valid, input sample, input record_end, output ready);
endinterface

interface led_out_if
    import led_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        is_minimum;
    logic [POS_BITS-1:0]         position;
    logic signed [PEAK_BITS-1:0] peak_value;

    modport source (output valid, output is_minimum, output position,
                    output peak_value, input ready);
    modport sink   (input valid, input is_minimum, input position,
                    input peak_value, output ready);
endinterface

interface led_cfg_if
    import led_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/led_cmp_tol.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_cmp_tol
// Tolerance compare of two signed samples: equal when they are identical
// or their absolute difference is below the tolerance, else greater or less.
// ----------------------------------------------------------------------------
module led_cmp_tol
    import led_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic        [TOL_BITS-1:0]    i_tol,
    output t_cmp                          o_rel
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = (DW > TOL_BITS) ? DW : TOL_BITS;

    logic signed [DW-1:0] a_ext;
    logic signed [DW-1:0] b_ext;
    logic        [DW-1:0] diff;
    logic                 a_ge_b;
    logic                 equal;

    assign a_ext  = DW'(i_a);
    assign b_ext  = DW'(i_b);
    assign a_ge_b = (a_ext >= b_ext);
    assign diff   = a_ge_b ? DW'(a_ext - b_ext) : DW'(b_ext - a_ext);
    assign equal  = (CW'(diff) < CW'(i_tol)) || (i_a == i_b);

    always_comb begin
        if (equal) begin
            o_rel = CMP_EQ;
        end else if (a_ge_b) begin
            o_rel = CMP_GT;
        end else begin
            o_rel = CMP_LT;
        end
    end

endmodule

>>> rtl/core/local_extrema_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_extrema_detector_unit
// Finds local maxima and minima, plateaus reported at their left edge, in
// records of signed samples.
//
// i_in carries one sample per item with record_end on the last sample of a
// record. o_out carries one item per reported extremum: kind, index within
// the record and sample value. i_cfg writes the equal tolerance (index 0) and
// the report mode (index 1); it is always ready. The user must write it
// only while idle; the block does not enforce this. A sample passes the
// input register, then the result register. Throughput: one sample per
// cycle unless o_out stalls, set by the single compare stage between them.
// When o_out stalls the result register holds its item; the input register
// still fills, then i_in.ready drops until the result is taken.
// Reset clears the trend state, the sample index, the pipeline valids and
// sets the registers to tolerance 1 and both kinds reported. After a sample
// with record_end the trend state and index return to their reset values.
// ----------------------------------------------------------------------------
module local_extrema_detector_unit
    import led_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    led_cfg_if.sink                             i_cfg,
    led_in_if.sink                              i_in,
    led_out_if.source                           o_out
);

    logic [TOL_BITS-1:0]           r_tol;
    logic [MODE_BITS-1:0]          r_mode;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_end;

    logic signed [SAMPLE_BITS-1:0] r_prev_sample, n_prev_sample;
    logic [INDEX_BITS-1:0]         r_prev_idx,    n_prev_idx;
    logic                          r_have_prev,   n_have_prev;
    t_trend                        r_trend,       n_trend;
    logic [INDEX_BITS-1:0]         r_cand_idx,    n_cand_idx;
    logic signed [SAMPLE_BITS-1:0] r_cand_val,    n_cand_val;
    logic [INDEX_BITS-1:0]         r_idx,         n_idx;

    logic                          r_out_valid,   n_out_valid;
    logic                          r_out_min,     n_out_min;
    logic [POS_BITS-1:0]           r_out_pos,     n_out_pos;
    logic signed [PEAK_BITS-1:0]   r_out_peak,    n_out_peak;

    logic   advance;
    logic   fire;
    t_cmp   rel_prev;
    t_cmp   rel_cand;
    t_cmp   dir_cmp;
    t_cmp   opp_cmp;
    logic   is_min;
    logic   wanted;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RESET;
            r_mode <= MODE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IDX_TOL:  r_tol  <= TOL_BITS'(i_cfg.data);
                CFG_IDX_MODE: r_mode <= MODE_BITS'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_sample <= i_in.sample;
            r_in_end    <= i_in.record_end;
        end
    end

    // compares
    led_cmp_tol #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmp_prev (
        .i_a   (r_in_sample),
        .i_b   (r_prev_sample),
        .i_tol (r_tol),
        .o_rel (rel_prev)
    );

    led_cmp_tol #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmp_cand (
        .i_a   (r_cand_val),
        .i_b   (r_in_sample),
        .i_tol (r_tol),
        .o_rel (rel_cand)
    );

    assign dir_cmp = (r_trend == TREND_RISING) ? CMP_GT : CMP_LT;
    assign opp_cmp = (r_trend == TREND_RISING) ? CMP_LT : CMP_GT;
    assign is_min  = (r_trend == TREND_FALLING);

    always_comb begin
        case (r_mode)
            MODE_MAX_ONLY: wanted = !is_min;
            MODE_MIN_ONLY: wanted = is_min;
            default:       wanted = 1'b1;
        endcase
    end

    // trend tracking and result
    always_comb begin
        n_prev_sample = r_prev_sample;
        n_prev_idx    = r_prev_idx;
        n_have_prev   = r_have_prev;
        n_trend       = r_trend;
        n_cand_idx    = r_cand_idx;
        n_cand_val    = r_cand_val;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_min     = r_out_min;
        n_out_pos     = r_out_pos;
        n_out_peak    = r_out_peak;

        if (fire) begin
            if (!r_have_prev) begin
                n_trend    = TREND_UNKNOWN;
                n_cand_idx = r_idx;
                n_cand_val = r_in_sample;
            end else if (r_trend == TREND_UNKNOWN) begin
                if (rel_prev != CMP_EQ) begin
                    n_trend    = (rel_prev == CMP_GT) ? TREND_RISING : TREND_FALLING;
                    n_cand_idx = r_idx;
                    n_cand_val = r_in_sample;
                end
            end else if (rel_prev == dir_cmp) begin
                n_cand_idx = r_idx;
                n_cand_val = r_in_sample;
            end else if (rel_cand == dir_cmp) begin
                n_out_valid = wanted;
                n_out_min   = is_min;
                n_out_pos   = POS_BITS'(r_cand_idx);
                n_out_peak  = PEAK_BITS'(r_cand_val);
                n_trend     = is_min ? TREND_RISING : TREND_FALLING;
                if (rel_prev == opp_cmp) begin
                    n_cand_idx = r_idx;
                    n_cand_val = r_in_sample;
                end else begin
                    n_cand_idx = r_prev_idx;
                    n_cand_val = r_prev_sample;
                end
            end

            n_prev_sample = r_in_sample;
            n_prev_idx    = r_idx;
            n_have_prev   = 1'b1;
            n_idx         = (r_idx == '1) ? r_idx : r_idx + 1'b1;

            if (r_in_end) begin
                n_have_prev = 1'b0;
                n_trend     = TREND_UNKNOWN;
                n_idx       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_trend     <= TREND_UNKNOWN;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_have_prev <= n_have_prev;
            r_trend     <= n_trend;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_sample <= n_prev_sample;
        r_prev_idx    <= n_prev_idx;
        r_cand_idx    <= n_cand_idx;
        r_cand_val    <= n_cand_val;
        r_out_min     <= n_out_min;
        r_out_pos     <= n_out_pos;
        r_out_peak    <= n_out_peak;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.is_minimum = r_out_min;
    assign o_out.position   = r_out_pos;
    assign o_out.peak_value = r_out_peak;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for local_extrema_detector_unit. A directed record set
// covers the sample extremes, plateaus, falling and flat starts and trailing
// flats. Shaped random records follow under several tolerance and report-mode
// settings, one run of them with items back to back on both sides.
// A bench-side extremum tracker predicts the extrema not fixed in the table.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import led_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [MODE_BITS-1:0] MODE_BOTH       = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_BOTH_ALIAS = 2'd3;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic                        is_minimum;
        logic [POS_BITS-1:0]         position;
        logic signed [PEAK_BITS-1:0] peak_value;
    } t_extremum;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_RESULT
    } t_row_check;

    typedef struct packed {
        t_sample    sample;
        logic       record_end;
        t_row_check check;
        t_extremum  result;
    } t_directed_row;

    localparam int NUM_DIRECTED = 21;

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        // rise, plateau, fall, then full-scale swings
        '{16'sd0,      1'b0, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}},
        '{16'sd10,     1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd20,     1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd20,     1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd5,      1'b0, ROW_RESULT,  '{1'b0, 16'd2, 16'sd20}},
        '{SAMPLE_MAX,  1'b0, ROW_RESULT,  '{1'b1, 16'd4, 16'sd5}},
        '{SAMPLE_MIN,  1'b0, ROW_RESULT,  '{1'b0, 16'd5, SAMPLE_MAX}},
        '{SAMPLE_MIN,  1'b1, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        // falling start with a plateau at the bottom
        '{16'sd100,    1'b0, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}},
        '{16'sd50,     1'b0, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}},
        '{16'sd50,     1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd80,     1'b1, ROW_RESULT,  '{1'b1, 16'd1, 16'sd50}},
        // flat start
        '{16'sd7,      1'b0, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}},
        '{16'sd7,      1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd7,      1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd9,      1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd3,      1'b1, ROW_RESULT,  '{1'b0, 16'd3, 16'sd9}},
        // trailing flat
        '{-16'sd5,     1'b0, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}},
        '{16'sd3,      1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd3,      1'b0, ROW_PREDICT, '{1'b0, 16'd0, 16'sd0}},
        '{16'sd3,      1'b1, ROW_NONE,    '{1'b0, 16'd0, 16'sd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    led_cfg_if cfg_if ();
    led_in_if  in_if ();
    led_out_if out_if ();

    local_extrema_detector_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // extremum tracker state and register copies
    logic [TOL_BITS-1:0]  cfg_tolerance;
    logic [MODE_BITS-1:0] cfg_mode;
    t_sample              trk_prev_sample;
    logic                 trk_have_prev;
    t_trend               trk_trend;
    logic [POS_BITS-1:0]  trk_cand_pos;
    t_sample              trk_cand_value;
    logic [POS_BITS-1:0]  trk_index;
    logic [POS_BITS-1:0]  trk_prev_index;

    t_extremum pending_extrema [$];
    int        mismatch_count = 0;
    bit        idle_enable = 1'b1;
    int        quiet_cycles = 0;

    function automatic void clear_tracking();
        trk_prev_sample = '0;
        trk_have_prev   = 1'b0;
        trk_trend       = TREND_UNKNOWN;
        trk_cand_pos    = '0;
        trk_cand_value  = '0;
        trk_index       = '0;
        trk_prev_index  = '0;
    endfunction

    function automatic t_cmp compare_tol(t_sample a, t_sample b);
        int ai;
        int bi;
        int diff;
        int tol;
        ai   = a;
        bi   = b;
        tol  = int'(cfg_tolerance);
        diff = (ai >= bi) ? ai - bi : bi - ai;
        if (diff < tol || ai == bi) begin
            return CMP_EQ;
        end
        return (ai > bi) ? CMP_GT : CMP_LT;
    endfunction

    function automatic bit track_sample(t_sample s, logic last, output t_extremum res);
        logic [POS_BITS-1:0] idx;
        t_cmp                step;
        t_cmp                dir;
        bit                  is_min;
        bit                  wanted;
        bit                  found;
        found = 1'b0;
        res   = '0;
        idx   = trk_index;
        if (!trk_have_prev) begin
            trk_trend      = TREND_UNKNOWN;
            trk_cand_pos   = idx;
            trk_cand_value = s;
        end else begin
            step = compare_tol(s, trk_prev_sample);
            if (trk_trend == TREND_UNKNOWN) begin
                if (step != CMP_EQ) begin
                    trk_trend      = (step == CMP_GT) ? TREND_RISING : TREND_FALLING;
                    trk_cand_pos   = idx;
                    trk_cand_value = s;
                end
            end else begin
                dir = (trk_trend == TREND_RISING) ? CMP_GT : CMP_LT;
                if (step == dir) begin
                    trk_cand_pos   = idx;
                    trk_cand_value = s;
                end
                if (compare_tol(trk_cand_value, s) == dir) begin
                    is_min = (trk_trend == TREND_FALLING);
                    case (cfg_mode)
                        MODE_MAX_ONLY: wanted = !is_min;
                        MODE_MIN_ONLY: wanted = is_min;
                        default:       wanted = 1'b1;
                    endcase
                    if (wanted) begin
                        found = 1'b1;
                        res   = '{is_min, trk_cand_pos, trk_cand_value};
                    end
                    trk_trend = is_min ? TREND_RISING : TREND_FALLING;
                    dir       = (dir == CMP_GT) ? CMP_LT : CMP_GT;
                    if (step == dir) begin
                        trk_cand_pos   = idx;
                        trk_cand_value = s;
                    end else begin
                        trk_cand_pos   = trk_prev_index;
                        trk_cand_value = trk_prev_sample;
                    end
                end
            end
        end
        trk_prev_sample = s;
        trk_prev_index  = idx;
        trk_have_prev   = 1'b1;
        if (idx != '1) begin
            trk_index = idx + 1'b1;
        end
        if (last) begin
            clear_tracking();
        end
        return found;
    endfunction

    task automatic send_sample(input t_sample s, input logic last, output bit found,
                               output t_extremum res);
        int gap;
        gap = idle_enable ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.sample     <= s;
        in_if.record_end <= last;
        do @(posedge i_clk); while (!in_if.ready);
        found = track_sample(s, last, res);
    endtask

    task automatic send_record(input int len, input int step_max, input int jump_pct);
        int        level;
        int        pick;
        bit        rising;
        bit        found;
        t_extremum res;
        level  = int'(t_sample'($urandom));
        rising = $urandom_range(0, 1);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < jump_pct / 2) begin
                level = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : int'(SAMPLE_MIN);
            end else if (pick < jump_pct) begin
                level = int'(t_sample'($urandom));
            end else if (pick >= jump_pct + 15) begin
                if ($urandom_range(0, 3) == 0) begin
                    rising = !rising;
                end
                level += rising ? int'($urandom_range(1, step_max))
                                : -int'($urandom_range(1, step_max));
                if (level > int'(SAMPLE_MAX)) level = int'(SAMPLE_MAX);
                if (level < int'(SAMPLE_MIN)) level = int'(SAMPLE_MIN);
            end
            send_sample(t_sample'(level), k == len - 1, found, res);
            if (found) begin
                pending_extrema.push_back(res);
            end
        end
    endtask

    task automatic run_records(input int items, input int step_max, input int jump_pct);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
            send_record(len, step_max, jump_pct);
            sent += len;
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_extrema.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [TOL_BITS-1:0] tol, input logic [MODE_BITS-1:0] mode);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_IDX_TOL;
        cfg_if.data  <= tol;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_tolerance = tol;
        cfg_if.index <= CFG_IDX_MODE;
        cfg_if.data  <= CFG_DATA_BITS'(mode);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_mode = mode;
        cfg_if.valid <= 1'b0;
    endtask

    // no item moved on any channel for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : result_check
        int        stall;
        t_extremum want;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_enable ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            if (pending_extrema.size() == 0) begin
                $error("unexpected item: is_minimum %0d position %0d peak_value %0d",
                       out_if.is_minimum, out_if.position, out_if.peak_value);
                mismatch_count++;
            end else begin
                want = pending_extrema.pop_front();
                if (out_if.is_minimum !== want.is_minimum) begin
                    $error("is_minimum: expected %0d, got %0d",
                           want.is_minimum, out_if.is_minimum);
                    mismatch_count++;
                end
                if (out_if.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, out_if.position);
                    mismatch_count++;
                end
                if (out_if.peak_value !== want.peak_value) begin
                    $error("peak_value: expected %0d, got %0d",
                           want.peak_value, out_if.peak_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        bit        found;
        t_extremum res;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.sample     <= '0;
        in_if.record_end <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_IDX_TOL;
        cfg_if.data      <= '0;
        cfg_tolerance = TOL_RESET;
        cfg_mode      = MODE_RESET;
        clear_tracking();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].sample, directed_rows[i].record_end, found, res);
            case (directed_rows[i].check)
                ROW_RESULT:  pending_extrema.push_back(directed_rows[i].result);
                ROW_PREDICT: if (found) pending_extrema.push_back(res);
                default:     ;
            endcase
        end

        // reset settings first, then the register extremes and both mode aliases
        run_records(100, 20, 4);
        wait_idle();
        set_config(16'd0, MODE_MAX_ONLY);
        run_records(100, 3, 4);
        wait_idle();
        set_config(16'hffff, MODE_MIN_ONLY);
        run_records(80, 200, 45);
        wait_idle();
        set_config(16'd300, MODE_BOTH_ALIAS);
        run_records(100, 600, 6);
        wait_idle();
        set_config(16'd1, MODE_MAX_ONLY);
        run_records(80, 10, 4);

        // items back to back on both sides, no idling
        wait_idle();
        set_config(16'd40, MODE_BOTH);
        idle_enable = 1'b0;
        run_records(40, 100, 4);
        wait_idle();
        idle_enable = 1'b1;
        set_config(TOL_RESET, MODE_MIN_ONLY);
        run_records(40, 15, 4);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
